FILE: rtl/core/sha1_pkg.sv
package sha1_pkg;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_FIRST_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } round_vars_t;

    typedef struct packed {
        logic       load_en;
        logic [7:0] load_byte;
        logic       step_en;
    } sched_ctrl_t;

    function automatic logic [31:0] iv_word(input logic [2:0] idx);
        logic [31:0] val;
        case (idx)
            3'd0:    val = 32'h67452301;
            3'd1:    val = 32'hEFCDAB89;
            3'd2:    val = 32'h98BADCFE;
            3'd3:    val = 32'h10325476;
            3'd4:    val = 32'hC3D2E1F0;
            default: val = 32'h0;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/core/sha1_sched.sv
module sha1_sched
    import sha1_pkg::*;
(
    input  logic        clk,
    input  sched_ctrl_t ctrl,
    output logic [31:0] w
);

    // the block buffer doubles as the rolling schedule window, word 0 on top
    logic [511:0] buf_reg;
    logic [511:0] buf_next;
    logic [31:0]  mix;

    assign w = buf_reg[511:480];

    always_comb
    begin
        mix = buf_reg[511:480] ^ buf_reg[447:416] ^ buf_reg[255:224] ^ buf_reg[95:64];
        buf_next = buf_reg;
        if (ctrl.load_en)
        begin
            buf_next = {buf_reg[503:0], ctrl.load_byte};
        end
        else if (ctrl.step_en)
        begin
            buf_next = {buf_reg[479:0], mix[30:0], mix[31]};
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

FILE: rtl/core/sha1_round.sv
module sha1_round
    import sha1_pkg::*;
(
    input  round_vars_t vars,
    input  logic [31:0] w,
    input  logic [6:0]  rnd,
    output round_vars_t vars_out
);

    logic [31:0] f;
    logic [31:0] k;

    always_comb
    begin
        if (rnd < 7'd20)
        begin
            f = (vars.b & vars.c) | (~vars.b & vars.d);
            k = K0;
        end
        else if (rnd < 7'd40)
        begin
            f = vars.b ^ vars.c ^ vars.d;
            k = K1;
        end
        else if (rnd < 7'd60)
        begin
            f = (vars.b & vars.c) | (vars.b & vars.d) | (vars.c & vars.d);
            k = K2;
        end
        else
        begin
            f = vars.b ^ vars.c ^ vars.d;
            k = K3;
        end
        vars_out.a = {vars.a[26:0], vars.a[31:27]} + f + vars.e + w + k;
        vars_out.b = vars.a;
        vars_out.c = {vars.b[1:0], vars.b[31:2]};
        vars_out.d = vars.c;
        vars_out.e = vars.d;
    end

endmodule

FILE: rtl/core/sha1_message_digest_core.sv
// one byte per transaction; a byte that fills a block starts its compression: the
// 80 rounds and then the chaining step, all on the shared round unit
// end of message: padding loads one byte a cycle up to the block end, then the 80 rounds
// and the chaining step; when the length does not fit, a second padded block is loaded
// and compressed the same way; then five digest words, one per cycle when taken
// input is held off while a block compresses, padding runs or the digest drains
// rst_n (async, active low) loads the initial hash and clears length, position and control
module sha1_message_digest_core
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] msg_byte
    input  logic [0:0]  s_tuser,   // [0] byte_valid
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] bit_count_reg, bit_count_next;
    logic [63:0] len_sh_reg, len_sh_next;
    logic        mode_pad_reg, mode_pad_next;
    logic        first_pad_reg, first_pad_next;
    logic        len_blk_reg, len_blk_next;
    logic        done_len_reg, done_len_next;
    logic [6:0]  rnd_reg, rnd_next;
    round_vars_t vars_reg, vars_next;
    logic [31:0] chain_reg [5];
    logic [31:0] chain_next [5];
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;

    sched_ctrl_t sched_ctrl;
    logic [31:0] w;
    round_vars_t round_out;

    sha1_sched u_sched (
        .clk  (clk),
        .ctrl (sched_ctrl),
        .w    (w)
    );

    sha1_round u_round (
        .vars     (vars_reg),
        .w        (w),
        .rnd      (rnd_reg),
        .vars_out (round_out)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == LAST_WORD_IDX);

    always_comb
    begin
        logic [5:0]  pos_v;
        logic [63:0] bc_v;
        logic [31:0] sum [5];

        pos_v = pos_reg;
        bc_v  = bit_count_reg;
        sum[0] = chain_reg[0] + vars_reg.a;
        sum[1] = chain_reg[1] + vars_reg.b;
        sum[2] = chain_reg[2] + vars_reg.c;
        sum[3] = chain_reg[3] + vars_reg.d;
        sum[4] = chain_reg[4] + vars_reg.e;

        state_next     = state_reg;
        pos_next       = pos_reg;
        bit_count_next = bit_count_reg;
        len_sh_next    = len_sh_reg;
        mode_pad_next  = mode_pad_reg;
        first_pad_next = first_pad_reg;
        len_blk_next   = len_blk_reg;
        done_len_next  = done_len_reg;
        rnd_next       = rnd_reg;
        vars_next      = vars_reg;
        for (int i = 0; i < 5; i++)
        begin
            chain_next[i] = chain_reg[i];
        end
        out_idx_next  = out_idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        sched_ctrl    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0])
                    begin
                        sched_ctrl.load_en   = 1'b1;
                        sched_ctrl.load_byte = s_tdata;
                        bc_v  = bit_count_reg + 64'd8;
                        pos_v = pos_reg + 6'd1;
                    end
                    pos_next       = pos_v;
                    bit_count_next = bc_v;
                    mode_pad_next  = s_tlast;
                    first_pad_next = 1'b1;
                    len_blk_next   = (pos_v < LEN_POS);
                    len_sh_next    = bc_v;
                    done_len_next  = 1'b0;
                    if (s_tuser[0] && pos_reg == LAST_POS)
                    begin
                        state_next = ST_ROUND;
                        rnd_next   = '0;
                        vars_next  = '{chain_reg[0], chain_reg[1], chain_reg[2],
                                       chain_reg[3], chain_reg[4]};
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                sched_ctrl.load_en = 1'b1;
                if (first_pad_reg)
                begin
                    sched_ctrl.load_byte = PAD_FIRST_BYTE;
                end
                else if (len_blk_reg && pos_reg >= LEN_POS)
                begin
                    // length goes out most significant byte first
                    sched_ctrl.load_byte = len_sh_reg[63:56];
                    len_sh_next = {len_sh_reg[55:0], 8'h00};
                end
                else
                begin
                    sched_ctrl.load_byte = 8'h00;
                end
                first_pad_next = 1'b0;
                pos_next = pos_reg + 6'd1;
                if (pos_reg == LAST_POS)
                begin
                    state_next = ST_ROUND;
                    rnd_next   = '0;
                    vars_next  = '{chain_reg[0], chain_reg[1], chain_reg[2],
                                   chain_reg[3], chain_reg[4]};
                    if (len_blk_reg)
                    begin
                        done_len_next = 1'b1;
                    end
                    else
                    begin
                        len_blk_next = 1'b1;
                    end
                end
            end
            ST_ROUND:
            begin
                sched_ctrl.step_en = 1'b1;
                vars_next = round_out;
                rnd_next  = rnd_reg + 7'd1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_next[i] = sum[i];
                end
                if (done_len_reg)
                begin
                    state_next    = ST_OUT;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = sum[0];
                    out_idx_next  = '0;
                end
                else if (mode_pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    if (out_idx_reg == LAST_WORD_IDX)
                    begin
                        // digest delivered, start a fresh message
                        m_tvalid_next  = 1'b0;
                        state_next     = ST_IDLE;
                        pos_next       = '0;
                        bit_count_next = '0;
                        mode_pad_next  = 1'b0;
                        done_len_next  = 1'b0;
                        for (int i = 0; i < 5; i++)
                        begin
                            chain_next[i] = iv_word(3'(i));
                        end
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                        m_tdata_next = chain_reg[out_idx_reg + 3'd1];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            bit_count_reg <= '0;
            mode_pad_reg  <= 1'b0;
            first_pad_reg <= 1'b0;
            len_blk_reg   <= 1'b0;
            done_len_reg  <= 1'b0;
            rnd_reg       <= '0;
            out_idx_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= iv_word(3'(i));
            end
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            bit_count_reg <= bit_count_next;
            mode_pad_reg  <= mode_pad_next;
            first_pad_reg <= first_pad_next;
            len_blk_reg   <= len_blk_next;
            done_len_reg  <= done_len_next;
            rnd_reg       <= rnd_next;
            out_idx_reg   <= out_idx_next;
            m_tvalid_reg  <= m_tvalid_next;
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_sh_reg  <= len_sh_next;
        vars_reg    <= vars_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

FILE: tb/sha1_digest_checker.sv
module sha1_digest_checker
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          words_due
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  pos;
        logic        last;
    } digest_word_t;

    logic [31:0]  hash_st [5];
    logic [7:0]   blk_bytes [64];
    logic [63:0]  msg_bits;
    logic [5:0]   fill_pos;
    digest_word_t digests [$];

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void start_message();
        hash_st[0] = 32'h67452301;
        hash_st[1] = 32'hEFCDAB89;
        hash_st[2] = 32'h98BADCFE;
        hash_st[3] = 32'h10325476;
        hash_st[4] = 32'hC3D2E1F0;
        msg_bits = 64'd0;
        fill_pos = 6'd0;
    endfunction

    function automatic void compress_blk();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        a = hash_st[0];
        b = hash_st[1];
        c = hash_st[2];
        d = hash_st[3];
        e = hash_st[4];
        for (int r = 0; r < 80; r++)
        begin
            // rolling 16-word schedule
            if (r >= 16)
                w[r % 16] = rol(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16]
                                ^ w[r % 16], 1);
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = rol(a, 5) + f + e + w[r % 16] + k;
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        hash_st[0] += a;
        hash_st[1] += b;
        hash_st[2] += c;
        hash_st[3] += d;
        hash_st[4] += e;
    endfunction

    function automatic void absorb(input logic [7:0] b, input logic bv, input logic eom);
        logic [63:0] len;
        int p;
        if (bv)
        begin
            blk_bytes[fill_pos] = b;
            msg_bits += 64'd8;
            fill_pos = fill_pos + 6'd1;
            if (fill_pos == 6'd0)
                compress_blk();
        end
        if (!eom)
            return;
        len = msg_bits;
        p = fill_pos;
        blk_bytes[p] = PAD_FIRST_BYTE;
        p++;
        // no room for the length field, so padding spills into one more block
        if (p > LEN_POS)
        begin
            while (p < 64)
            begin
                blk_bytes[p] = 8'h00;
                p++;
            end
            compress_blk();
            p = 0;
        end
        while (p < LEN_POS)
        begin
            blk_bytes[p] = 8'h00;
            p++;
        end
        for (int i = 0; i < 8; i++)
            blk_bytes[LEN_POS + i] = len[63 - 8*i -: 8];
        compress_blk();
        for (int i = 0; i < 5; i++)
            digests.push_back('{hash_st[i], 3'(i), i == 4});
        start_message();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: digest %s mismatch, got %0h, want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_word();
        digest_word_t exp_w;
        if (digests.size() == 0)
        begin
            report_mismatch("unexpected word", m_tdata, 32'h0);
            return;
        end
        exp_w = digests.pop_front();
        if (m_tdata !== exp_w.word)
            report_mismatch("word", m_tdata, exp_w.word);
        if (m_tuser !== exp_w.pos)
            report_mismatch("index", 32'(m_tuser), 32'(exp_w.pos));
        if (m_tlast !== exp_w.last)
            report_mismatch("last flag", 32'(m_tlast), 32'(exp_w.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_message();
            digests.delete();
            fail_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                absorb(s_tdata, s_tuser[0], s_tlast);
            if (m_tvalid && m_tready)
                check_word();
        end
        words_due = digests.size();
    end

endmodule

FILE: tb/sha1_message_digest_core_test.sv
module sha1_message_digest_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          words_due;

    int accepted;
    int rand_msgs;
    bit no_gaps;
    bit rand_phase;

    sha1_message_digest_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sha1_digest_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // one transaction; returns at the edge where it was taken
    task automatic push_byte(input logic [7:0] b, input logic bv, input logic eom);
        while (!no_gaps && $urandom_range(99) < 21)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= bv;
        s_tlast  <= eom;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (bv || eom)
            accepted++;
    endtask

    // step past the accepting edge so the checker has counted the last transaction
    task automatic wait_drained();
        @(posedge clk);
        wait (words_due == 0);
    endtask

    task automatic send_message(input int n_bytes, input bit split_end);
        for (int i = 0; i < n_bytes; i++)
        begin
            if ($urandom_range(99) < 8)
                push_byte(8'($urandom), 1'b0, 1'b0);
            push_byte(8'($urandom), 1'b1, (i == n_bytes - 1) && !split_end);
        end
        if (split_end || n_bytes == 0)
            push_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    // lengths cluster around the padding boundaries
    function automatic int pick_len();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4)
            return $urandom_range(8);
        if (sel < 8)
        begin
            case ($urandom_range(8))
                0: return 54;
                1: return 55;
                2: return 56;
                3: return 57;
                4: return 63;
                5: return 64;
                6: return 65;
                7: return 119;
                default: return 120;
            endcase
        end
        return $urandom_range(130);
    endfunction

    initial
    begin : result_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held = 0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!held && rand_phase && m_tvalid)
            begin
                // long back-pressure while the sender keeps offering bytes
                held = 1;
                hold_left = 300;
                m_tready <= 1'b0;
            end
            else
                m_tready <= no_gaps || ($urandom_range(99) >= 21);
        end
    end

    initial
    begin
        accepted = 0;
        rand_msgs = 0;
        no_gaps = 0;
        rand_phase = 0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        rst_n    <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, junk byte must be ignored
        push_byte(8'hFF, 1'b0, 1'b1);
        // "abc" with the last byte carrying the end mark
        push_byte(8'h61, 1'b1, 1'b0);
        push_byte(8'h62, 1'b1, 1'b0);
        push_byte(8'h63, 1'b1, 1'b1);
        // idle transactions change nothing
        push_byte(8'hA5, 1'b0, 1'b0);
        push_byte(8'h5A, 1'b0, 1'b0);
        push_byte(8'h00, 1'b1, 1'b1);
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b1);
        push_byte(8'h61, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h62, 1'b1, 1'b0);
        push_byte(8'h63, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'hFF, 1'b1, 1'b1);

        wait_drained();
        rand_phase = 1;
        while (accepted < 264 || rand_msgs < 4)
        begin
            no_gaps = (rand_msgs >= 1 && rand_msgs < 3);
            if (rand_msgs == 3)
                wait_drained();
            send_message(pick_len(), $urandom_range(2) == 0);
            rand_msgs++;
        end
        no_gaps = 0;
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0 && words_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/sha1_pkg.sv
rtl/core/sha1_sched.sv
rtl/core/sha1_round.sv
rtl/core/sha1_message_digest_core.sv
tb/sha1_digest_checker.sv
tb/sha1_message_digest_core_test.sv
